// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// When the trigger holds, the result must hold in the next cycle.
`define ASSERT_NEXT(label, trig, res, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) \
		else $error(msg);

`endif

// ----- rtl/cylen_pkg.sv -----
`default_nettype none

package cylen_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PLATFORM_JOINT_X   = 3'd0,
		REG_PLATFORM_JOINT_Y   = 3'd1,
		REG_UPPER_JOINT_HEIGHT = 3'd2,
		REG_GROUND_JOINT_X     = 3'd3,
		REG_GROUND_JOINT_Y     = 3'd4,
		REG_GROUND_JOINT_DEPTH = 3'd5,
		REG_MAX_ANGLE          = 3'd6,
		REG_MAX_LENGTH         = 3'd7
	} cfg_reg_t;

	localparam int CW = 34;         // CORDIC vector and angle width, Q30
	localparam int LW = 23;         // length width, Q15.8
	localparam int AW = 13;         // angle limit width
	localparam int SUMW = 56;       // sum of squares width, Q16
	localparam int ROOTW = SUMW / 2;
	localparam int DW = 28;         // rounded coordinate difference width

	localparam logic [AW-1:0] ANGLE_CAP = 13'd6434;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

	localparam logic [31:0] ATAN_Q30 [24] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

endpackage

`default_nettype wire

// ----- rtl/cylen_cordic.sv -----
`default_nettype none

// Rotation-mode CORDIC, one micro-rotation per register stage.
module cylen_cordic import cylen_pkg::*; #(
	parameter int STEPS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [CW-1:0] z_in,
	output logic signed [CW-1:0]      cos_out,
	output logic signed [CW-1:0]      sin_out
);

	logic signed [CW-1:0] x_s [STEPS];
	logic signed [CW-1:0] y_s [STEPS];
	logic signed [CW-1:0] z_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CW-1:0] x_in, y_in, z_cur, dx, dy, ang;

		// The first step starts from the gain-corrected unit vector.
		if (i == 0) begin : g_first
			assign x_in = CORDIC_GAIN;
			assign y_in = '0;
			assign z_cur = z_in;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_cur = z_s[i-1];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign ang = $signed({2'b00, ATAN_Q30[i]});

		// Rotate toward the remaining angle.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_cur[CW-1]) begin
					x_s[i] <= x_in - dx;
					y_s[i] <= y_in + dy;
					z_s[i] <= z_cur - ang;
				end else begin
					x_s[i] <= x_in + dx;
					y_s[i] <= y_in - dy;
					z_s[i] <= z_cur + ang;
				end
			end
		end
	end

	assign cos_out = x_s[STEPS-1];
	assign sin_out = y_s[STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/cylen_isqrt.sv -----
`default_nettype none

// Floor square root, one result bit per register stage.
module cylen_isqrt import cylen_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [SUMW-1:0]  radicand,
	output logic [ROOTW-1:0]      root
);

	logic [SUMW:0] v_s [ROOTW];
	logic [SUMW:0] r_s [ROOTW];

	for (genvar j = 0; j < ROOTW; j++) begin : g_bit
		localparam int SH = 2 * (ROOTW - 1 - j);
		logic [SUMW:0] v_in, r_in, trial;

		if (j == 0) begin : g_first
			assign v_in = {1'b0, radicand};
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[j-1];
			assign r_in = r_s[j-1];
		end

		assign trial = r_in + ((SUMW+1)'(1) << SH);

		// Keep the bit when the trial value still fits the remainder.
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_s[j] <= v_in - trial;
					r_s[j] <= (r_in >> 1) + ((SUMW+1)'(1) << SH);
				end else begin
					v_s[j] <= v_in;
					r_s[j] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_s[ROOTW-1][ROOTW-1:0];

endmodule

`default_nettype wire

// ----- rtl/platform_cylinder_length_solver.sv -----
`default_nettype none
// Channel   Direction  Beat contents (lowest bits first)
// s_*       in         pitch_angle[15:0], bank_angle[31:16]
// m_*       out        length_one[22:0], length_two[45:23], zero pad [47:46]
// cfg_*     in         register write: index, 23-bit data
//
// One beat enters per cycle while the output buffer has room.
// Each beat passes through the clamp stage, the CORDIC stages, seven arithmetic
// stages and the 28 stages of the bit-per-stage square root.
// Reset clears the valid bits, the output buffer and the registers to defaults.
// The pipeline advances as a whole while the two-entry output buffer has room,
// so a stalled output side holds every beat in place.

`include "assert_macros.svh"

module platform_cylinder_length_solver import cylen_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // pitch_angle, bank_angle
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // length_one, length_two, pad
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [LW-1:0] cfg_data
);

	localparam int LAT = 1 + CORDIC_STEPS + 7 + ROOTW;

	logic [LW-1:0] pjx_q, pjy_q, ujh_q, gjx_q, gjy_q, gjd_q, max_length_q;
	logic [AW-1:0] max_angle_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pjx_q <= '0;
			pjy_q <= '0;
			ujh_q <= '0;
			gjx_q <= '0;
			gjy_q <= '0;
			gjd_q <= '0;
			max_angle_q <= ANGLE_CAP;
			max_length_q <= '1;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PLATFORM_JOINT_X:   pjx_q <= cfg_data;
				REG_PLATFORM_JOINT_Y:   pjy_q <= cfg_data;
				REG_UPPER_JOINT_HEIGHT: ujh_q <= cfg_data;
				REG_GROUND_JOINT_X:     gjx_q <= cfg_data;
				REG_GROUND_JOINT_Y:     gjy_q <= cfg_data;
				REG_GROUND_JOINT_DEPTH: gjd_q <= cfg_data;
				REG_MAX_ANGLE:          max_angle_q <= cfg_data[AW-1:0];
				REG_MAX_LENGTH:         max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [1:0] count_q;
	logic       en;
	logic [LAT-1:0] vld_q;

	assign en = (count_q != 2'd2);
	assign s_tready = en;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Stage 1: clamp both angles and move them to Q30.
	logic [AW-1:0] lim;
	logic signed [16:0] lim_p, lim_n, pitch_a, bank_a, pitch_c, bank_c;
	logic signed [CW-1:0] pitch_z_s1, bank_z_s1;

	always_comb begin
		lim = (max_angle_q > ANGLE_CAP) ? ANGLE_CAP : max_angle_q;
		lim_p = $signed({4'b0000, lim});
		lim_n = -lim_p;
		pitch_a = 17'(signed'(s_tdata[15:0]));
		bank_a = 17'(signed'(s_tdata[31:16]));
		pitch_c = (pitch_a > lim_p) ? lim_p : ((pitch_a < lim_n) ? lim_n : pitch_a);
		bank_c = (bank_a > lim_p) ? lim_p : ((bank_a < lim_n) ? lim_n : bank_a);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_z_s1 <= $signed({pitch_c[15:0], 18'b0});
			bank_z_s1 <= $signed({bank_c[15:0], 18'b0});
		end
	end

	// Sine and cosine of both angles.
	logic signed [CW-1:0] cx, sx, cy, sy;

	cylen_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
		.clk(clk), .en(en), .z_in(pitch_z_s1), .cos_out(cx), .sin_out(sx)
	);

	cylen_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_bank (
		.clk(clk), .en(en), .z_in(bank_z_s1), .cos_out(cy), .sin_out(sy)
	);

	// Stage 2: products of trig values for the matrix.
	logic signed [2*CW-1:0] pss_s2, pcs_s2, psc_s2, pcc_s2;
	logic signed [CW-1:0] cx_s2, sx_s2, cy_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pss_s2 <= sx * sy;
			pcs_s2 <= cx * sy;
			psc_s2 <= sx * cy;
			pcc_s2 <= cx * cy;
			cx_s2 <= cx;
			sx_s2 <= sx;
			cy_s2 <= cy;
			sy_s2 <= sy;
		end
	end

	// Stage 3: round the products back to Q30.
	localparam logic signed [2*CW-1:0] HALF_P = (2*CW)'(1) <<< 29;
	logic signed [2*CW-1:0] m1_r, m2_r, m7_r, m8_r;
	logic signed [CW-1:0] m1_s3, m2_s3, m7_s3, m8_s3, cx_s3, sx_s3, cy_s3, sy_s3;

	assign m1_r = (pss_s2 + HALF_P) >>> 30;
	assign m2_r = (pcs_s2 + HALF_P) >>> 30;
	assign m7_r = (psc_s2 + HALF_P) >>> 30;
	assign m8_r = (pcc_s2 + HALF_P) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s3 <= m1_r[CW-1:0];
			m2_s3 <= m2_r[CW-1:0];
			m7_s3 <= m7_r[CW-1:0];
			m8_s3 <= m8_r[CW-1:0];
			cx_s3 <= cx_s2;
			sx_s3 <= sx_s2;
			cy_s3 <= cy_s2;
			sy_s3 <= sy_s2;
		end
	end

	// Stage 4: matrix entries times joint coordinates.
	localparam int PW = CW + LW + 1;
	logic signed [LW:0] pjx_v, pjy_v, ujh_v;
	logic signed [PW-1:0] cy_px_s4, m2_h_s4, m1_py_s4, sx_h_s4, cx_py_s4;
	logic signed [PW-1:0] sy_px_s4, m8_h_s4, m7_py_s4;

	assign pjx_v = $signed({1'b0, pjx_q});
	assign pjy_v = $signed({1'b0, pjy_q});
	assign ujh_v = $signed({1'b0, ujh_q});

	always_ff @(posedge clk) begin
		if (en) begin
			cy_px_s4 <= cy_s3 * pjx_v;
			m2_h_s4 <= m2_s3 * ujh_v;
			m1_py_s4 <= m1_s3 * pjy_v;
			sx_h_s4 <= sx_s3 * ujh_v;
			cx_py_s4 <= cx_s3 * pjy_v;
			sy_px_s4 <= sy_s3 * pjx_v;
			m8_h_s4 <= m8_s3 * ujh_v;
			m7_py_s4 <= m7_s3 * pjy_v;
		end
	end

	// Stage 5: split each row into the shared part and the lateral part,
	// with the ground offsets and the rounding half folded in.
	localparam int EW = 60;
	localparam logic signed [EW-1:0] HALF_E = EW'(1) <<< 29;
	logic signed [EW-1:0] gx_e, gy_e, gd_e;
	logic signed [EW-1:0] c0_s5, c1_s5, c2_s5, d0_s5, d1_s5, d2_s5;

	assign gx_e = $signed({{(EW-LW-30){1'b0}}, gjx_q, 30'b0});
	assign gy_e = $signed({{(EW-LW-30){1'b0}}, gjy_q, 30'b0});
	assign gd_e = $signed({{(EW-LW-30){1'b0}}, gjd_q, 30'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s5 <= EW'(m2_h_s4) - EW'(cy_px_s4) + gx_e + HALF_E;
			c1_s5 <= HALF_E - EW'(sx_h_s4);
			c2_s5 <= EW'(sy_px_s4) + EW'(m8_h_s4) + gd_e + HALF_E;
			d0_s5 <= EW'(m1_py_s4);
			d1_s5 <= EW'(cx_py_s4) - gy_e;
			d2_s5 <= EW'(m7_py_s4);
		end
	end

	// Stage 6: coordinate differences for both cylinders, rounded to Q8.
	logic signed [EW-1:0] e10, e11, e12, e20, e21, e22;
	logic signed [DW-1:0] d10_s6, d11_s6, d12_s6, d20_s6, d21_s6, d22_s6;

	assign e10 = (c0_s5 + d0_s5) >>> 30;
	assign e11 = (c1_s5 + d1_s5) >>> 30;
	assign e12 = (c2_s5 + d2_s5) >>> 30;
	assign e20 = (c0_s5 - d0_s5) >>> 30;
	assign e21 = (c1_s5 - d1_s5) >>> 30;
	assign e22 = (c2_s5 - d2_s5) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			d10_s6 <= e10[DW-1:0];
			d11_s6 <= e11[DW-1:0];
			d12_s6 <= e12[DW-1:0];
			d20_s6 <= e20[DW-1:0];
			d21_s6 <= e21[DW-1:0];
			d22_s6 <= e22[DW-1:0];
		end
	end

	// Stage 7: squares.
	logic [SUMW-1:0] q10_s7, q11_s7, q12_s7, q20_s7, q21_s7, q22_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			q10_s7 <= SUMW'(d10_s6 * d10_s6);
			q11_s7 <= SUMW'(d11_s6 * d11_s6);
			q12_s7 <= SUMW'(d12_s6 * d12_s6);
			q20_s7 <= SUMW'(d20_s6 * d20_s6);
			q21_s7 <= SUMW'(d21_s6 * d21_s6);
			q22_s7 <= SUMW'(d22_s6 * d22_s6);
		end
	end

	// Stage 8: sums of squares.
	logic [SUMW-1:0] sum1_s8, sum2_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			sum1_s8 <= q10_s7 + q11_s7 + q12_s7;
			sum2_s8 <= q20_s7 + q21_s7 + q22_s7;
		end
	end

	// Distances.
	logic [ROOTW-1:0] root1, root2;

	cylen_isqrt u_isqrt_one (.clk(clk), .en(en), .radicand(sum1_s8), .root(root1));
	cylen_isqrt u_isqrt_two (.clk(clk), .en(en), .radicand(sum2_s8), .root(root2));

	// Saturate at the length limit.
	logic [ROOTW-1:0] max_len_w;
	logic [LW-1:0] len1, len2;
	logic [2*LW-1:0] res;

	assign max_len_w = {{(ROOTW-LW){1'b0}}, max_length_q};
	assign len1 = (root1 > max_len_w) ? max_length_q : root1[LW-1:0];
	assign len2 = (root2 > max_len_w) ? max_length_q : root2[LW-1:0];
	assign res = {len2, len1};

	// Two-entry output buffer.
	logic [2*LW-1:0] e0_q, e1_q;
	logic push, pop;

	assign push = en && vld_q[LAT-1];
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && pop) begin
			e0_q <= res;
		end else if (push) begin
			if (count_q == 2'd0) begin
				e0_q <= res;
			end else begin
				e1_q <= res;
			end
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata = {2'b00, e0_q};

	// Checks.
	`ASSERT_ALWAYS(a_count_range, count_q != 2'd3, "output buffer count out of range")
	`ASSERT_ALWAYS(a_len_limit, !m_tvalid || (e0_q[LW-1:0] <= max_length_q && e0_q[2*LW-1:LW] <= max_length_q), "length above limit")
	`ASSERT_NEXT(a_stall_hold, !en && vld_q[LAT-1], vld_q[LAT-1], "stalled result lost")

endmodule

`default_nettype wire
